### hdl/epa_pkg.sv
// types and constants shared by the ellipse perimeter approximator
`timescale 1ns / 1ps
`default_nettype none

package epa_pkg;

    // semi-axis and result widths
    localparam int AXIS_W = 16;
    localparam int OUT_W  = 20;

    // transaction payloads
    typedef struct packed {
        logic [AXIS_W-1:0] axis_a;
        logic [AXIS_W-1:0] axis_b;
    } t_axes;

    typedef struct packed {
        logic [OUT_W-1:0] perimeter_r1;
        logic [OUT_W-1:0] perimeter_r2;
        logic [OUT_W-1:0] perimeter_hud;
    } t_perims;

    // pi as 314159 / 100000
    localparam logic [18:0] PI_NUM = 19'd314159;

    // unit sizes
    localparam int SUM_W = AXIS_W + 1;      // a + b
    localparam int Q_W   = 36;              // (3a+b)(a+3b)
    localparam int DD_W  = 2 * AXIS_W;      // (a-b)^2
    localparam int SS_W  = 2 * SUM_W;       // (a+b)^2
    localparam int HN_W  = 53;              // h numerator
    localparam int HQ_W  = 21;              // h in q0.20, up to and including one
    localparam int RT_W  = 26;              // root width of both square roots
    localparam int MN_W  = 45;              // numerator of t and 1/(1-h/4)
    localparam int MD_W  = 24;              // divisor of t and 1/(1-h/4)
    localparam int DIF_W = 27;              // 3s*2^8 - r
    localparam int FN_W  = 62;              // final numerators

    // halves of the final divisors 100000 * 2^8, 2^20 and 2^24 for round to nearest
    localparam logic [FN_W-1:0] R1_HALF  = 62'd12800000;
    localparam logic [FN_W-1:0] R2_HALF  = 62'd52428800000;
    localparam logic [FN_W-1:0] HUD_HALF = 62'd838860800000;

    // final divisors as 3125 * 2^shift: a shift, then a divide by 3125
    localparam int DQ_W   = 32;             // shifted numerator
    localparam int RC_W   = 21;             // reciprocal of 3125
    localparam int QE_W   = 21;             // quotient estimate
    localparam int DK_W   = 12;             // 3125
    localparam int BK_W   = QE_W + DK_W;    // estimate times 3125
    localparam int R1_SH  = 13;
    localparam int R2_SH  = 25;
    localparam int HUD_SH = 29;
    localparam logic [DK_W-1:0] DIV_K   = 12'd3125;
    localparam logic [RC_W-1:0] RECIP_K = 21'd1374389;     // floor(2^32 / 3125)
    localparam logic [DQ_W-1:0] SAT_LIM = 32'd3276800000;  // 3125 * 2^20

    // h equal to one in q0.20
    localparam logic [HN_W-1:0] HQ_ONE = 53'd1048576;

endpackage

`default_nettype wire

### hdl/epa_div.sv
// pipelined dividers: restoring divider by a variable, reciprocal scaler by a constant
`timescale 1ns / 1ps
`default_nettype none

module epa_div #(
    parameter int NW = 8,
    parameter int DW = 8,
    parameter int SW = 1
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_en,
    input  wire logic          i_valid,
    input  wire logic [NW-1:0] i_num,
    input  wire logic [DW-1:0] i_den,
    input  wire logic [SW-1:0] i_side,
    output logic               o_valid,
    output logic      [NW-1:0] o_quo,
    output logic      [SW-1:0] o_side
);

    logic [NW-1:0] r_vld;
    logic [DW-1:0] r_rem  [NW];
    logic [DW-1:0] n_rem  [NW];
    logic [NW-1:0] r_num  [NW];
    logic [NW-1:0] n_num  [NW];
    logic [NW-1:0] r_quo  [NW];
    logic [NW-1:0] n_quo  [NW];
    logic [DW-1:0] r_den  [NW];
    logic [DW-1:0] n_den  [NW];
    logic [SW-1:0] r_side [NW];
    logic [SW-1:0] n_side [NW];

    // each stage shifts in one numerator bit and tries a subtract
    always_comb begin
        int            j;
        logic [DW-1:0] s_rem;
        logic [NW-1:0] s_num;
        logic [NW-1:0] s_quo;
        logic [DW-1:0] s_den;
        logic [SW-1:0] s_side;
        logic [DW:0]   trial;
        logic [DW:0]   diff;
        for (int k = 0; k < NW; k++) begin
            j = (k == 0) ? 0 : k - 1;
            if (k == 0) begin
                s_rem  = '0;
                s_num  = i_num;
                s_quo  = '0;
                s_den  = i_den;
                s_side = i_side;
            end else begin
                s_rem  = r_rem[j];
                s_num  = r_num[j];
                s_quo  = r_quo[j];
                s_den  = r_den[j];
                s_side = r_side[j];
            end
            trial = {s_rem, s_num[NW-1]};
            diff  = trial - {1'b0, s_den};
            if (trial >= {1'b0, s_den}) begin
                n_rem[k] = diff[DW-1:0];
                n_quo[k] = {s_quo[NW-2:0], 1'b1};
            end else begin
                n_rem[k] = trial[DW-1:0];
                n_quo[k] = {s_quo[NW-2:0], 1'b0};
            end
            n_num[k]  = {s_num[NW-2:0], 1'b0};
            n_den[k]  = s_den;
            n_side[k] = s_side;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[NW-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < NW; k++) begin
                r_rem[k]  <= n_rem[k];
                r_num[k]  <= n_num[k];
                r_quo[k]  <= n_quo[k];
                r_den[k]  <= n_den[k];
                r_side[k] <= n_side[k];
            end
        end
    end

    assign o_valid = r_vld[NW-1];
    assign o_quo   = r_quo[NW-1];
    assign o_side  = r_side[NW-1];

endmodule

// divide by 3125 * 2^SH in three stages: shift and reciprocal estimate, estimate times 3125, one correction
module epa_scale #(
    parameter int SH = 13
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_en,
    input  wire logic                      i_valid,
    input  wire logic [epa_pkg::FN_W-1:0]  i_num,
    input  wire logic                      i_zero,
    output logic                           o_valid,
    output logic      [epa_pkg::OUT_W-1:0] o_res
);

    import epa_pkg::*;

    logic [DQ_W-1:0]      w_red;
    logic                 w_over;
    logic [DQ_W+RC_W-1:0] w_prod;

    // the quotient fits 20 bits only while the shifted numerator is below 3125 * 2^20
    assign w_red  = i_num[SH +: DQ_W];
    assign w_over = (|i_num[FN_W-1:SH+DQ_W]) || (w_red >= SAT_LIM);
    assign w_prod = {{RC_W{1'b0}}, w_red} * {{DQ_W{1'b0}}, RECIP_K};

    // stage a: estimate, low by at most one
    logic            r_a_vld;
    logic            r_a_zero;
    logic            r_a_over;
    logic [DQ_W-1:0] r_a_red;
    logic [QE_W-1:0] r_a_qe;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else if (i_en) begin
            r_a_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_zero <= i_zero;
            r_a_over <= w_over;
            r_a_red  <= w_red;
            r_a_qe   <= w_prod[DQ_W+RC_W-1:DQ_W];
        end
    end

    // stage b: estimate times 3125
    logic            r_b_vld;
    logic            r_b_zero;
    logic            r_b_over;
    logic [DQ_W-1:0] r_b_red;
    logic [QE_W-1:0] r_b_qe;
    logic [BK_W-1:0] r_b_back;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_vld <= 1'b0;
        end else if (i_en) begin
            r_b_vld <= r_a_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_b_zero <= r_a_zero;
            r_b_over <= r_a_over;
            r_b_red  <= r_a_red;
            r_b_qe   <= r_a_qe;
            r_b_back <= {{DK_W{1'b0}}, r_a_qe} * {{QE_W{1'b0}}, DIV_K};
        end
    end

    // stage c: remainder check, zero sum and saturation, output register
    logic [BK_W-1:0]  w_rem;
    logic [QE_W-1:0]  w_qe1;
    logic             r_c_vld;
    logic [OUT_W-1:0] r_c_res;

    assign w_rem = {{(BK_W-DQ_W){1'b0}}, r_b_red} - r_b_back;
    assign w_qe1 = r_b_qe + QE_W'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_vld <= 1'b0;
        end else if (i_en) begin
            r_c_vld <= r_b_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (r_b_zero) begin
                r_c_res <= '0;
            end else if (r_b_over) begin
                r_c_res <= '1;
            end else if (w_rem >= {{(BK_W-DK_W){1'b0}}, DIV_K}) begin
                r_c_res <= w_qe1[OUT_W-1:0];
            end else begin
                r_c_res <= r_b_qe[OUT_W-1:0];
            end
        end
    end

    assign o_valid = r_c_vld;
    assign o_res   = r_c_res;

endmodule

`default_nettype wire

### hdl/epa_sqrt.sv
// pipelined integer square root, one root bit per stage
`timescale 1ns / 1ps
`default_nettype none

module epa_sqrt #(
    parameter int RW = 8,
    parameter int SW = 1
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_en,
    input  wire logic            i_valid,
    input  wire logic [2*RW-1:0] i_rad,
    input  wire logic [SW-1:0]   i_side,
    output logic                 o_valid,
    output logic      [RW-1:0]   o_root,
    output logic      [SW-1:0]   o_side
);

    logic [RW-1:0]   r_vld;
    logic [RW+1:0]   r_rem  [RW];
    logic [RW+1:0]   n_rem  [RW];
    logic [2*RW-1:0] r_rad  [RW];
    logic [2*RW-1:0] n_rad  [RW];
    logic [RW-1:0]   r_root [RW];
    logic [RW-1:0]   n_root [RW];
    logic [SW-1:0]   r_side [RW];
    logic [SW-1:0]   n_side [RW];

    // digit by digit: bring down two radicand bits, try root*4+1
    always_comb begin
        int              j;
        logic [RW+1:0]   s_rem;
        logic [2*RW-1:0] s_rad;
        logic [RW-1:0]   s_root;
        logic [SW-1:0]   s_side;
        logic [RW+1:0]   trial;
        logic [RW+1:0]   test;
        for (int k = 0; k < RW; k++) begin
            j = (k == 0) ? 0 : k - 1;
            if (k == 0) begin
                s_rem  = '0;
                s_rad  = i_rad;
                s_root = '0;
                s_side = i_side;
            end else begin
                s_rem  = r_rem[j];
                s_rad  = r_rad[j];
                s_root = r_root[j];
                s_side = r_side[j];
            end
            trial = {s_rem[RW-1:0], s_rad[2*RW-1 -: 2]};
            test  = {s_root, 2'b01};
            if (trial >= test) begin
                n_rem[k]  = trial - test;
                n_root[k] = {s_root[RW-2:0], 1'b1};
            end else begin
                n_rem[k]  = trial;
                n_root[k] = {s_root[RW-2:0], 1'b0};
            end
            n_rad[k]  = {s_rad[2*RW-3:0], 2'b00};
            n_side[k] = s_side;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[RW-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < RW; k++) begin
                r_rem[k]  <= n_rem[k];
                r_rad[k]  <= n_rad[k];
                r_root[k] <= n_root[k];
                r_side[k] <= n_side[k];
            end
        end
    end

    assign o_valid = r_vld[RW-1];
    assign o_root  = r_root[RW-1];
    assign o_side  = r_side[RW-1];

endmodule

`default_nettype wire

### hdl/ellipse_perimeter_approximator.sv
// top level of the ellipse perimeter approximator
`timescale 1ns / 1ps
`default_nettype none

// Takes a pair of unsigned q8.8 semi-axes per transaction and returns three q12.8
// circumference estimates, rounded to nearest and saturated to 0xfffff: Ramanujan's
// first and second approximations and Hudson's formula, with pi taken as 3.14159.
// A zero axis sum gives all three outputs zero. The block is a single pipeline that
// takes a new transaction every cycle while o_ready is high; its depth is set by the
// chain of bit-per-stage units: the 53-stage divider for h, the 26-stage square
// roots and the 45-stage dividers for the second approximation and 1/(1-h/4),
// plus six register stages of multipliers and adders and a three-stage scaler that
// divides by pi's denominator through a shift and a reciprocal multiply. The whole
// pipeline holds while a result waits at the output, so o_ready drops only while
// the output is full and i_ready is low.
module ellipse_perimeter_approximator (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_valid,
    output logic                 o_ready,
    input  wire epa_pkg::t_axes  i_data,
    output logic                 o_valid,
    input  wire logic            i_ready,
    output epa_pkg::t_perims     o_data
);

    import epa_pkg::*;

    // global advance for every stage
    logic w_en;
    logic w_fin_vld;

    assign w_en    = !w_fin_vld || i_ready;
    assign o_ready = w_en;
    assign o_valid = w_fin_vld;

    // ---------------------------------------------------------------
    // input register
    // ---------------------------------------------------------------
    logic              r_p0_vld;
    logic [AXIS_W-1:0] r_p0_a;
    logic [AXIS_W-1:0] r_p0_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p0_vld <= 1'b0;
        end else if (w_en) begin
            r_p0_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_p0_a <= i_data.axis_a;
            r_p0_b <= i_data.axis_b;
        end
    end

    // ---------------------------------------------------------------
    // sum, products (3a+b)(a+3b), (a-b)^2 and (a+b)^2
    // ---------------------------------------------------------------
    logic [SUM_W-1:0]  w_s;
    logic [SUM_W:0]    w_u;
    logic [SUM_W:0]    w_v;
    logic [AXIS_W-1:0] w_d;

    assign w_s = {1'b0, r_p0_a} + {1'b0, r_p0_b};
    assign w_u = {r_p0_a, 1'b0} + {2'b00, r_p0_a} + {2'b00, r_p0_b};
    assign w_v = {r_p0_b, 1'b0} + {2'b00, r_p0_b} + {2'b00, r_p0_a};
    assign w_d = (r_p0_a > r_p0_b) ? (r_p0_a - r_p0_b) : (r_p0_b - r_p0_a);

    logic             r_p1_vld;
    logic             r_p1_zero;
    logic [SUM_W-1:0] r_p1_s;
    logic [Q_W-1:0]   r_p1_q;
    logic [DD_W-1:0]  r_p1_dd;
    logic [SS_W-1:0]  r_p1_ss;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_vld <= 1'b0;
        end else if (w_en) begin
            r_p1_vld <= r_p0_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_p1_zero <= (w_s == '0);
            r_p1_s    <= w_s;
            r_p1_q    <= w_u * w_v;
            r_p1_dd   <= w_d * w_d;
            r_p1_ss   <= w_s * w_s;
        end
    end

    // ---------------------------------------------------------------
    // h = round((a-b)^2 * 2^20 / (a+b)^2)
    // ---------------------------------------------------------------
    localparam int HS_W = 1 + SUM_W + Q_W;

    logic [HN_W-1:0] w_h_num;
    logic            w_h_vld;
    logic [HN_W-1:0] w_h_quo;
    logic [HS_W-1:0] w_h_side;
    logic            w_h_zero;
    logic [SUM_W-1:0] w_h_s;
    logic [Q_W-1:0]  w_h_q;
    logic [HQ_W-1:0] w_hq;

    assign w_h_num = {1'b0, r_p1_dd, 20'b0} + {20'b0, r_p1_ss[SS_W-1:1]};

    epa_div #(
        .NW (HN_W),
        .DW (SS_W),
        .SW (HS_W)
    ) u_hdiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_p1_vld),
        .i_num   (w_h_num),
        .i_den   (r_p1_ss),
        .i_side  ({r_p1_zero, r_p1_s, r_p1_q}),
        .o_valid (w_h_vld),
        .o_quo   (w_h_quo),
        .o_side  (w_h_side)
    );

    assign {w_h_zero, w_h_s, w_h_q} = w_h_side;
    assign w_hq = w_h_quo[HQ_W-1:0];

    // ---------------------------------------------------------------
    // square roots: sqrt(q * 2^16) for the first estimate and
    // sqrt((4 - 3h) * 2^40) for the second, side by side
    // ---------------------------------------------------------------
    logic [HQ_W+1:0]   w_hq3;
    logic [HQ_W+1:0]   w_rad2;
    logic [2*RT_W-1:0] w_x1;
    logic [2*RT_W-1:0] w_x2;

    assign w_hq3  = {w_hq, 1'b0} + {2'b00, w_hq};
    assign w_rad2 = 23'h400000 - w_hq3;
    assign w_x1   = {w_h_q, 16'b0};
    assign w_x2   = {9'b0, w_rad2, 20'b0};

    logic              w_sa_vld;
    logic [RT_W-1:0]   w_sa_root;
    logic [SUM_W:0]    w_sa_side;
    logic              w_sb_vld;
    logic [RT_W-1:0]   w_sb_root;
    logic [HQ_W-1:0]   w_sb_hq;
    logic              w_sa_zero;
    logic [SUM_W-1:0]  w_sa_s;

    epa_sqrt #(
        .RW (RT_W),
        .SW (SUM_W + 1)
    ) u_sqrt_r1 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_h_vld),
        .i_rad   (w_x1),
        .i_side  ({w_h_zero, w_h_s}),
        .o_valid (w_sa_vld),
        .o_root  (w_sa_root),
        .o_side  (w_sa_side)
    );

    epa_sqrt #(
        .RW (RT_W),
        .SW (HQ_W)
    ) u_sqrt_r2 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_h_vld),
        .i_rad   (w_x2),
        .i_side  (w_hq),
        .o_valid (w_sb_vld),
        .o_root  (w_sb_root),
        .o_side  (w_sb_hq)
    );

    assign {w_sa_zero, w_sa_s} = w_sa_side;

    // ---------------------------------------------------------------
    // first estimate difference, then t = round(3h / (10 + sq)) and
    // inv = round(1 / (1 - h/4)) through two equal dividers
    // ---------------------------------------------------------------
    logic [SUM_W+1:0] w_s3;
    logic [DIF_W-1:0] w_diff;
    logic [HQ_W+1:0]  w_m_hq3;
    logic [MD_W-1:0]  w_dt;
    logic [MN_W-1:0]  w_nt;
    logic [MD_W-1:0]  w_di;
    logic [MN_W-1:0]  w_ni;

    assign w_s3    = {w_sa_s, 1'b0} + {2'b00, w_sa_s};
    assign w_diff  = {w_s3, 8'b0} - {1'b0, w_sa_root};
    assign w_m_hq3 = {w_sb_hq, 1'b0} + {2'b00, w_sb_hq};
    assign w_dt    = 24'hA00000 + w_sb_root[MD_W-1:0];
    assign w_nt    = {2'b00, w_m_hq3, 20'b0} + {22'b0, w_dt[MD_W-1:1]};
    assign w_di    = 24'h400000 - {3'b000, w_sb_hq};
    assign w_ni    = {1'b1, 44'b0} + {22'b0, w_di[MD_W-1:1]};

    localparam int TS_W = 1 + SUM_W + DIF_W;

    logic             w_t_vld;
    logic [MN_W-1:0]  w_t_quo;
    logic [TS_W-1:0]  w_t_side;
    logic             w_i_vld;
    logic [MN_W-1:0]  w_i_quo;
    logic [HQ_W-1:0]  w_i_hq;
    logic             w_t_zero;
    logic [SUM_W-1:0] w_t_s;
    logic [DIF_W-1:0] w_t_diff;

    epa_div #(
        .NW (MN_W),
        .DW (MD_W),
        .SW (TS_W)
    ) u_tdiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_sa_vld),
        .i_num   (w_nt),
        .i_den   (w_dt),
        .i_side  ({w_sa_zero, w_sa_s, w_diff}),
        .o_valid (w_t_vld),
        .o_quo   (w_t_quo),
        .o_side  (w_t_side)
    );

    epa_div #(
        .NW (MN_W),
        .DW (MD_W),
        .SW (HQ_W)
    ) u_idiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_sb_vld),
        .i_num   (w_ni),
        .i_den   (w_di),
        .i_side  (w_sb_hq),
        .o_valid (w_i_vld),
        .o_quo   (w_i_quo),
        .o_side  (w_i_hq)
    );

    assign {w_t_zero, w_t_s, w_t_diff} = w_t_side;

    // ---------------------------------------------------------------
    // 1 + t and Hudson's bracket k = 3(1 + h/4) + inv, q.22
    // ---------------------------------------------------------------
    logic [22:0] w_one_h;
    logic [24:0] w_k;

    assign w_one_h = 23'h400000 + {2'b00, w_i_hq};
    assign w_k     = {1'b0, w_one_h, 1'b0} + {2'b00, w_one_h} + {2'b00, w_i_quo[22:0]};

    logic             r_p5_vld;
    logic             r_p5_zero;
    logic [SUM_W-1:0] r_p5_s;
    logic [DIF_W-1:0] r_p5_diff;
    logic [20:0]      r_p5_t1;
    logic [24:0]      r_p5_k;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p5_vld <= 1'b0;
        end else if (w_en) begin
            r_p5_vld <= w_t_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_p5_zero <= w_t_zero;
            r_p5_s    <= w_t_s;
            r_p5_diff <= w_t_diff;
            r_p5_t1   <= 21'h100000 + w_t_quo[20:0];
            r_p5_k    <= w_k;
        end
    end

    // ---------------------------------------------------------------
    // s * (1 + t), s * k, and pi times the first estimate difference
    // ---------------------------------------------------------------
    logic        r_p6_vld;
    logic        r_p6_zero;
    logic [37:0] r_p6_x2;
    logic [41:0] r_p6_x3;
    logic [45:0] r_p6_m1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p6_vld <= 1'b0;
        end else if (w_en) begin
            r_p6_vld <= r_p5_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_p6_zero <= r_p5_zero;
            r_p6_x2   <= r_p5_s * r_p5_t1;
            r_p6_x3   <= r_p5_s * r_p5_k;
            r_p6_m1   <= r_p5_diff * PI_NUM;
        end
    end

    // ---------------------------------------------------------------
    // pi times the wide products, split into high and low halves
    // ---------------------------------------------------------------
    logic        r_p7_vld;
    logic        r_p7_zero;
    logic [45:0] r_p7_m1;
    logic [37:0] r_p7_p2h;
    logic [37:0] r_p7_p2l;
    logic [39:0] r_p7_p3h;
    logic [39:0] r_p7_p3l;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p7_vld <= 1'b0;
        end else if (w_en) begin
            r_p7_vld <= r_p6_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_p7_zero <= r_p6_zero;
            r_p7_m1   <= r_p6_m1;
            r_p7_p2h  <= r_p6_x2[37:19] * PI_NUM;
            r_p7_p2l  <= r_p6_x2[18:0] * PI_NUM;
            r_p7_p3h  <= r_p6_x3[41:21] * PI_NUM;
            r_p7_p3l  <= r_p6_x3[20:0] * PI_NUM;
        end
    end

    // ---------------------------------------------------------------
    // final numerators with the rounding half added
    // ---------------------------------------------------------------
    logic            r_p8_vld;
    logic            r_p8_zero;
    logic [FN_W-1:0] r_p8_n1;
    logic [FN_W-1:0] r_p8_n2;
    logic [FN_W-1:0] r_p8_n3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p8_vld <= 1'b0;
        end else if (w_en) begin
            r_p8_vld <= r_p7_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_p8_zero <= r_p7_zero;
            r_p8_n1   <= {16'b0, r_p7_m1} + R1_HALF;
            r_p8_n2   <= {5'b0, r_p7_p2h, 19'b0} + {24'b0, r_p7_p2l} + R2_HALF;
            r_p8_n3   <= {1'b0, r_p7_p3h, 21'b0} + {22'b0, r_p7_p3l} + HUD_HALF;
        end
    end

    // ---------------------------------------------------------------
    // final scaling by 100000 * 2^f, the last stage is the output register;
    // zero sum forces zero, anything past 20 bits saturates
    // ---------------------------------------------------------------
    logic             w_f2_vld;
    logic             w_f3_vld;
    logic [OUT_W-1:0] w_f1_res;
    logic [OUT_W-1:0] w_f2_res;
    logic [OUT_W-1:0] w_f3_res;

    epa_scale #(
        .SH (R1_SH)
    ) u_scale_r1 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_p8_vld),
        .i_num   (r_p8_n1),
        .i_zero  (r_p8_zero),
        .o_valid (w_fin_vld),
        .o_res   (w_f1_res)
    );

    epa_scale #(
        .SH (R2_SH)
    ) u_scale_r2 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_p8_vld),
        .i_num   (r_p8_n2),
        .i_zero  (r_p8_zero),
        .o_valid (w_f2_vld),
        .o_res   (w_f2_res)
    );

    epa_scale #(
        .SH (HUD_SH)
    ) u_scale_hud (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_p8_vld),
        .i_num   (r_p8_n3),
        .i_zero  (r_p8_zero),
        .o_valid (w_f3_vld),
        .o_res   (w_f3_res)
    );

    always_comb begin
        o_data.perimeter_r1  = w_f1_res;
        o_data.perimeter_r2  = w_f2_res;
        o_data.perimeter_hud = w_f3_res;
    end

    // ---------------------------------------------------------------
    // assertions
    // ---------------------------------------------------------------

    // parallel units must stay in step
    a_sqrt_align : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_sa_vld == w_sb_vld)
        else $error("square root lanes out of step");

    a_mid_align : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_t_vld == w_i_vld)
        else $error("t and inverse dividers out of step");

    a_fin_align : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fin_vld == w_f2_vld) && (w_fin_vld == w_f3_vld))
        else $error("final scalers out of step");

    // h never exceeds one for a non-zero sum
    a_hq_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_h_vld && !w_h_zero) |-> (w_h_quo <= HQ_ONE))
        else $error("h above one");

    // sqrt(4 - 3h) is at least one, so 1 - h/4 stays away from zero
    a_sq_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_sa_vld && !w_sa_zero) |-> (w_sb_root >= 26'h100000))
        else $error("sqrt(4 - 3h) below one");

endmodule

`default_nettype wire

### tb/sv/ellipse_perimeter_approximator_tb.sv
// testbench for the ellipse perimeter approximator
`timescale 1ns / 1ps

module ellipse_perimeter_approximator_tb;
    import epa_pkg::*;

    localparam int LATENCY = 133;
    localparam longint unsigned OUT_MAX = 64'hFFFFF;

    logic    i_clk = 1'b0;
    logic    i_rst_n;
    logic    i_valid;
    logic    o_ready;
    t_axes   i_data;
    logic    o_valid;
    logic    i_ready;
    t_perims o_data;

    // perimeters still owed by the block, oldest first
    t_perims owed_perims[$];
    int      mismatches = 0;
    bit      calm = 1'b0;      // no idling on either side when set
    int      hold_cycles = 0;  // long receiver hold-off, counted down below

    ellipse_perimeter_approximator uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (o_data)
    );

    always #6 i_clk = ~i_clk;

    // integer square root, floor
    function automatic longint unsigned root_floor(longint unsigned v);
        longint unsigned r, bitv;
        r = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv >>= 2;
        while (bitv != 0) begin
            if (v >= r + bitv) begin
                v -= r + bitv;
                r = (r >> 1) + bitv;
            end else begin
                r >>= 1;
            end
            bitv >>= 2;
        end
        return r;
    endfunction

    // division rounded to nearest, halves up
    function automatic longint unsigned div_near(longint unsigned n, longint unsigned d);
        if (d == 0) return 0;
        return (n + d / 2) / d;
    endfunction

    function automatic logic [OUT_W-1:0] clamp_out(longint unsigned v);
        return (v > OUT_MAX) ? OUT_W'(OUT_MAX) : OUT_W'(v);
    endfunction

    // expected perimeters for one axis pair
    function automatic t_perims perimeters_of(t_axes ax);
        longint unsigned a, b, s, q, r, d, hq, sq, t, inv, k;
        t_perims p;
        a = ax.axis_a;
        b = ax.axis_b;
        s = a + b;
        if (s == 0) begin
            p = '0;
            return p;
        end
        if (s > (64'd1 << 19)) begin
            p.perimeter_r1  = '1;
            p.perimeter_r2  = '1;
            p.perimeter_hud = '1;
            return p;
        end
        // ramanujan first
        q = (3 * a + b) * (a + 3 * b);
        r = root_floor(q << 16);
        p.perimeter_r1 = clamp_out(div_near(64'd314159 * (((3 * s) << 8) - r),
                                            64'd100000 << 8));
        // h in q0.20
        d = (a > b) ? a - b : b - a;
        hq = div_near((d * d) << 20, s * s);
        // ramanujan second
        sq = root_floor(((64'd4 << 20) - 3 * hq) << 20);
        t = div_near((3 * hq) << 20, (64'd10 << 20) + sq);
        p.perimeter_r2 = clamp_out(div_near(64'd314159 * s * ((64'd1 << 20) + t),
                                            64'd100000 << 20));
        // hudson
        inv = div_near(64'd1 << 44, (64'd1 << 22) - hq);
        k = 3 * ((64'd1 << 22) + hq) + inv;
        p.perimeter_hud = clamp_out(div_near(64'd314159 * s * k, 64'd100000 << 24));
        return p;
    endfunction

    // offer one axis pair and hold it until the block takes it
    task automatic send_axes(logic [AXIS_W-1:0] a, logic [AXIS_W-1:0] b);
        t_axes ax;
        int gap;
        ax.axis_a = a;
        ax.axis_b = b;
        i_valid <= 1'b1;
        i_data  <= ax;
        do @(posedge i_clk); while (!o_ready);
        owed_perims.push_back(perimeters_of(ax));
        // occasional idle burst after a transaction
        if (!calm && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 6);
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic drain_results();
        i_valid <= 1'b0;
        while (owed_perims.size() != 0) @(posedge i_clk);
    endtask

    // receiver: random stalls, long hold-off on request, result checking
    int stall_left = 0;
    always @(posedge i_clk) begin
        t_perims want;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                if (owed_perims.size() == 0) begin
                    $display("%0t: unexpected result %h", $time, o_data);
                    mismatches++;
                end else begin
                    want = owed_perims.pop_front();
                    if (o_data.perimeter_r1 !== want.perimeter_r1) begin
                        $display("%0t: r1 expected %h actual %h", $time,
                                 want.perimeter_r1, o_data.perimeter_r1);
                        mismatches++;
                    end
                    if (o_data.perimeter_r2 !== want.perimeter_r2) begin
                        $display("%0t: r2 expected %h actual %h", $time,
                                 want.perimeter_r2, o_data.perimeter_r2);
                        mismatches++;
                    end
                    if (o_data.perimeter_hud !== want.perimeter_hud) begin
                        $display("%0t: hud expected %h actual %h", $time,
                                 want.perimeter_hud, o_data.perimeter_hud);
                        mismatches++;
                    end
                end
            end
            if (hold_cycles > 0) begin
                hold_cycles <= hold_cycles - 1;
                i_ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left <= stall_left - 1;
                i_ready <= 1'b0;
            end else if (!calm && $urandom_range(0, 7) == 0) begin
                stall_left <= $urandom_range(0, 5);
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    // extremes, zero sum, equal axes, one axis zero
    task automatic test_directed();
        send_axes('0, '0);
        send_axes('1, '1);
        send_axes('1, '0);
        send_axes('0, '1);
        send_axes(16'h0001, 16'h0000);
        send_axes(16'h0000, 16'h0001);
        send_axes(16'h0001, 16'h0001);
        send_axes(16'h0100, 16'h0100);
        send_axes(16'h0300, 16'h0100);
        send_axes(16'h8000, 16'h8000);
        send_axes(16'hFFFF, 16'h0001);
        send_axes(16'h0001, 16'hFFFF);
        send_axes(16'hAAAA, 16'h5555);
        send_axes(16'h5555, 16'hAAAA);
        send_axes(16'h7FFF, 16'h8000);
        send_axes(16'h0002, 16'hFFFE);
        send_axes(16'h1234, 16'h0000);
    endtask

    function automatic logic [AXIS_W-1:0] pick_axis();
        case ($urandom_range(0, 4))
            0: return AXIS_W'($urandom_range(0, 255));
            1: return AXIS_W'($urandom_range(0, 4095));
            2: return '1 - AXIS_W'($urandom_range(0, 3));
            default: return AXIS_W'($urandom);
        endcase
    endfunction

    task automatic test_random(int count);
        logic [AXIS_W-1:0] a, b;
        repeat (count) begin
            a = pick_axis();
            case ($urandom_range(0, 9))
                0: b = a;
                1: b = '0;
                2: b = a + AXIS_W'($urandom_range(0, 3));
                default: b = pick_axis();
            endcase
            if ($urandom_range(0, 1)) send_axes(a, b);
            else send_axes(b, a);
        end
    endtask

    // receiver holds off long enough for the pipeline to fill and stall its input
    task automatic test_backpressure();
        hold_cycles = 3 * LATENCY;
        test_random(400);
    endtask

    // sender waits until every owed result has come, then goes on
    task automatic test_pause();
        test_random(50);
        drain_results();
        test_random(50);
    endtask

    task automatic test_streaming();
        calm = 1'b1;
        test_random(250);
    endtask

    initial begin
        int guard;
        i_rst_n <= 1'b0;
        i_valid <= 1'b0;
        i_data  <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_random(580);
        test_backpressure();
        test_pause();
        test_streaming();

        i_valid <= 1'b0;
        guard = 0;
        while (owed_perims.size() != 0 && guard < 100000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (LATENCY + 20) @(posedge i_clk);
        if (mismatches == 0 && owed_perims.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    // overall time limit
    initial begin
        #20ms;
        $display("FAIL");
        $finish;
    end

endmodule
